// ===== hw/rtl/ffg_pkg.sv =====
// Shared types, constants, cell-update and state-cleaning functions for the forest-fire grid step.
// No dependencies; imported by every module of the block.

package ffg_pkg;

  localparam int ST_W        = 2;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 10;
  localparam int GROWS_W     = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 11;
  localparam int MAX_COLS_DEF = 48;
  localparam int ROWS_MAX    = 1024;

  localparam logic [ST_W-1:0] ST_EMPTY = 2'd0;
  localparam logic [ST_W-1:0] ST_TREE  = 2'd1;
  localparam logic [ST_W-1:0] ST_BURN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  localparam logic [GROWS_W-1:0] ROWS_RESET = 11'd30;
  localparam logic [COL_W-1:0]   COLS_RESET = 6'd40;

  // Control shared by every cell of a line buffer chain.
  typedef struct packed {
    logic             shift;
    logic [COL_W-1:0] start;
  } lb_ctrl_t;

  function automatic logic [ST_W-1:0] next_cell(input logic [ST_W-1:0] centre,
                                                input logic hot);
    logic [ST_W-1:0] res;
    res = centre;
    if (centre == ST_BURN) begin
      res = ST_EMPTY;
    end else if (centre == ST_TREE && hot) begin
      res = ST_BURN;
    end
    return res;
  endfunction

  // Unused code three reads as empty.
  function automatic logic [ST_W-1:0] clean_state(input logic [ST_W-1:0] raw);
    return (raw == ST_EMPTY || raw == ST_TREE || raw == ST_BURN) ? raw : ST_EMPTY;
  endfunction

endpackage

// ===== hw/rtl/ffg_cell.sv =====
// One storage cell of a line buffer chain: holds one grid cell state.
// Depends on ffg_pkg.

module ffg_cell
  import ffg_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  lb_ctrl_t        ctrl,
  input  logic [ST_W-1:0] din,
  input  logic [ST_W-1:0] prev,
  output logic [ST_W-1:0] q
);

  logic is_entry;

  // The entry cell takes the fresh beat, so the live chain is exactly one row long.
  assign is_entry = (ctrl.start == COL_W'(IDX));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q <= is_entry ? din : prev;
    end
  end

endmodule

// ===== hw/rtl/ffg_chain.sv =====
// Row-length line buffer built as a chain of ffg_cell, entry point set by the column count.
// Depends on ffg_pkg and ffg_cell.

module ffg_chain
  import ffg_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic            clk,
  input  lb_ctrl_t        ctrl,
  input  logic [ST_W-1:0] din,
  output logic [ST_W-1:0] tail,
  output logic [ST_W-1:0] tail_prev
);

  logic [ST_W-1:0] q [MAX_COLS];

  for (genvar j = 0; j < MAX_COLS; j++) begin : g_cell
    if (j == 0) begin : g_head
      ffg_cell #(.IDX(j)) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .din  (din),
        .prev (din),
        .q    (q[j])
      );
    end else begin : g_body
      ffg_cell #(.IDX(j)) u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .din  (din),
        .prev (q[j-1]),
        .q    (q[j])
      );
    end
  end

  assign tail      = q[MAX_COLS-1];
  assign tail_prev = q[MAX_COLS-2];

endmodule

// ===== hw/rtl/forest_fire_grid_step_top.sv =====
// Top level of the forest-fire grid step: counters, update logic and output register.
// Depends on ffg_pkg and ffg_chain.

// One generation of a forest-fire automaton over a raster-ordered stream, one cell per
// beat. Results lag the input by one row: the beat at (r, c) yields the result for
// (r-1, c). Two line buffers, each a chain of cells whose live length equals the
// column count (grid_cols, with 0 taken as 1 and anything above MAX_COLS as MAX_COLS),
// hold the previous two rows. The input takes one beat per cycle while the output
// register is free; after the last beat of a frame the block stalls its input while the
// final row is flushed from the chains, one result per cycle while the output register
// is free, so any output stall prolongs the flush. The last result carries frame_end
// and still_burning. Configuration writes restart the frame.

module forest_fire_grid_step_top
  import ffg_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ST_W-1:0]      cell_state,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ST_W-1:0]      next_state,
  output logic [ROW_W-1:0]     out_row,
  output logic [COL_W-1:0]     out_col,
  output logic                 frame_end,
  output logic                 still_burning
);

  logic [GROWS_W-1:0] grid_rows;
  logic [COL_W-1:0]   grid_cols;
  logic [ROW_W-1:0]   row_counter;
  logic [COL_W-1:0]   col_counter;
  logic               burning_seen;
  logic               flushing;
  logic [ST_W-1:0]    prev_centre;

  logic [GROWS_W-1:0] rows_eff;
  logic [COL_W-1:0]   cols_eff;
  logic               out_free;
  logic               accept;
  logic               flush_step;
  logic               last_row;
  logic               last_col;
  logic               emit;
  logic               hot;
  logic [ST_W-1:0]    ns;
  logic [ST_W-1:0]    cell_clean;
  logic [ST_W-1:0]    c1_tail, c1_prev, c2_tail, c2_prev;
  lb_ctrl_t           lb_ctrl;

  always_comb begin
    priority if (grid_rows == '0) begin
      rows_eff = GROWS_W'(1);
    end else if (grid_rows > GROWS_W'(ROWS_MAX)) begin
      rows_eff = GROWS_W'(ROWS_MAX);
    end else begin
      rows_eff = grid_rows;
    end
    priority if (grid_cols == '0) begin
      cols_eff = COL_W'(1);
    end else if (grid_cols > COL_W'(MAX_COLS)) begin
      cols_eff = COL_W'(MAX_COLS);
    end else begin
      cols_eff = grid_cols;
    end
  end

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = flushing || (out_valid && out_stall);
  assign accept     = in_valid && !in_stall;
  assign flush_step = flushing && out_free;
  assign last_row   = ({1'b0, row_counter} + GROWS_W'(1)) >= rows_eff;
  assign last_col   = ({1'b0, col_counter} + (COL_W+1)'(1)) >= {1'b0, cols_eff};
  assign cell_clean = clean_state(cell_state);

  assign lb_ctrl.shift = accept || flush_step;
  assign lb_ctrl.start = COL_W'(MAX_COLS) - cols_eff;

  ffg_chain #(.MAX_COLS(MAX_COLS)) u_middle (
    .clk       (clk),
    .ctrl      (lb_ctrl),
    .din       (flushing ? ST_EMPTY : cell_clean),
    .tail      (c1_tail),
    .tail_prev (c1_prev)
  );

  ffg_chain #(.MAX_COLS(MAX_COLS)) u_upper (
    .clk       (clk),
    .ctrl      (lb_ctrl),
    .din       (c1_tail),
    .tail      (c2_tail),
    .tail_prev (c2_prev)
  );

  // The upper chain's second tap is not needed; the left neighbour is the held centre.
  logic unused_tap;
  assign unused_tap = ^c2_prev;

  // Centre is the middle-chain tail; during flush there is no row below.
  always_comb begin
    logic up_ok;
    up_ok = flushing ? (row_counter != '0) : (row_counter >= ROW_W'(2));
    hot = (!flushing && cell_clean == ST_BURN)
       || (up_ok && c2_tail == ST_BURN)
       || (col_counter != '0 && prev_centre == ST_BURN)
       || (!last_col && c1_prev == ST_BURN)
       || (unused_tap && 1'b0);
    ns   = next_cell(c1_tail, hot);
    emit = flush_step || (accept && row_counter != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows    <= ROWS_RESET;
      grid_cols    <= COLS_RESET;
      row_counter  <= '0;
      col_counter  <= '0;
      burning_seen <= 1'b0;
      flushing     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid     <= 1'b1;
        next_state    <= ns;
        out_row       <= flushing ? row_counter : row_counter - ROW_W'(1);
        out_col       <= col_counter;
        frame_end     <= flushing && last_col;
        still_burning <= flushing && last_col && (burning_seen || ns == ST_BURN);
        if (ns == ST_BURN) begin
          burning_seen <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (lb_ctrl.shift) begin
        prev_centre <= c1_tail;
      end

      priority if (flush_step) begin
        if (last_col) begin
          row_counter  <= '0;
          col_counter  <= '0;
          burning_seen <= 1'b0;
          flushing     <= 1'b0;
        end else begin
          col_counter <= col_counter + COL_W'(1);
        end
      end else if (accept) begin
        priority if (last_row && last_col) begin
          col_counter <= '0;
          flushing    <= 1'b1;
        end else if (last_col) begin
          col_counter <= '0;
          row_counter <= row_counter + ROW_W'(1);
        end else begin
          col_counter <= col_counter + COL_W'(1);
        end
      end

      // A write to a listed register restarts the frame.
      if (cfg_wr_en && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS)) begin
        if (cfg_index == CFG_ROWS) begin
          grid_rows <= cfg_wr_data;
        end else begin
          grid_cols <= cfg_wr_data[COL_W-1:0];
        end
        row_counter  <= '0;
        col_counter  <= '0;
        burning_seen <= 1'b0;
        flushing     <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_flush_holds_input: assert property (@(posedge clk) disable iff (rst)
    flushing |-> in_stall)
    else $error("input taken during row flush");

  a_flush_on_last_row: assert property (@(posedge clk) disable iff (rst)
    flushing |-> last_row)
    else $error("flush outside the last row");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    col_counter < cols_eff)
    else $error("column counter beyond row length");

  a_burn_flag_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !frame_end) |-> !still_burning)
    else $error("still_burning set away from frame end");

  a_last_beat_starts_flush: assert property (@(posedge clk) disable iff (rst)
    (accept && last_row && last_col && !cfg_wr_en) |=> flushing)
    else $error("last beat of frame did not start flush");
`endif

endmodule

// ===== dv/forest_fire_grid_step_top_test.sv =====
// Self-checking testbench for forest_fire_grid_step_top: directed table, then random frames.
// Predicts each generation from its own copy of the line buffers; needs ffg_pkg and the RTL.

module forest_fire_grid_step_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ffg_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 5;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int ITEM_TARGET     = 340;
  localparam int CYCLE_LIMIT     = 200000;

  localparam logic [ST_W-1:0]      ST_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  typedef struct packed {
    logic [ST_W-1:0]  state;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             fend;
    logic             still;
  } fire_cell_t;

  typedef enum logic {WRITE_REG, FEED_CELL} step_kind_t;

  typedef struct packed {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    logic                 typed;
    fire_cell_t           want;
  } dir_step_t;

  localparam fire_cell_t NO_RESULT  = '0;
  // A one-cell frame: the only result is also the frame end.
  localparam fire_cell_t LONE_EMPTY = '{ST_EMPTY, 10'd0, 6'd0, 1'b1, 1'b0};
  localparam fire_cell_t LONE_TREE  = '{ST_TREE, 10'd0, 6'd0, 1'b1, 1'b0};

  localparam int NUM_DIRECTED = 38;
  localparam dir_step_t DIRECTED [NUM_DIRECTED] = '{
    '{WRITE_REG, CFG_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{WRITE_REG, CFG_COLS, 11'd1, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_BURN}, 1'b1, LONE_EMPTY},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b1, LONE_TREE},
    '{FEED_CELL, '0, {9'd0, ST_EMPTY}, 1'b1, LONE_EMPTY},
    '{FEED_CELL, '0, {9'd0, ST_UNUSED}, 1'b1, LONE_EMPTY},
    // zero rows and columns act as one
    '{WRITE_REG, CFG_ROWS, 11'd0, 1'b0, NO_RESULT},
    '{WRITE_REG, CFG_COLS, 11'd0, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b1, LONE_TREE},
    '{WRITE_REG, CFG_ROWS, 11'd3, 1'b0, NO_RESULT},
    '{WRITE_REG, CFG_COLS, 11'd3, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_BURN}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_UNUSED}, 1'b0, NO_RESULT},
    // single row: everything comes from the flush
    '{WRITE_REG, CFG_ROWS, 11'd1, 1'b0, NO_RESULT},
    '{WRITE_REG, CFG_COLS, 11'd4, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_BURN}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_BURN}, 1'b0, NO_RESULT},
    '{WRITE_REG, CFG_ROWS, 11'd2, 1'b0, NO_RESULT},
    '{WRITE_REG, CFG_COLS, 11'd2, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_BURN}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    // unlisted index: frame carries on
    '{WRITE_REG, CFG_SPARE3, 11'h7FF, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{WRITE_REG, CFG_SPARE2, 11'h555, 1'b0, NO_RESULT},
    // listed index mid-frame: restart
    '{WRITE_REG, CFG_ROWS, 11'd2, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_BURN}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT},
    '{FEED_CELL, '0, {9'd0, ST_TREE}, 1'b0, NO_RESULT}
  };

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [ST_W-1:0]      cell_state  = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [ST_W-1:0]      next_state;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic                 frame_end;
  logic                 still_burning;

  forest_fire_grid_step_top dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state
  logic [GROWS_W-1:0] rows_reg = ROWS_RESET;
  logic [COL_W-1:0]   cols_reg = COLS_RESET;
  logic [ST_W-1:0]    row_above2 [MAX_COLS_DEF];
  logic [ST_W-1:0]    row_above  [MAX_COLS_DEF];
  int unsigned        row_pos     = 0;
  int unsigned        col_pos     = 0;
  bit                 any_burning = 1'b0;

  fire_cell_t step_out [$];
  fire_cell_t next_gen_q [$];

  int errors    = 0;
  int cells_fed = 0;
  int cycles    = 0;
  bit sender_gaps_on  = 1'b1;
  bit stall_bursts_on = 1'b1;
  bit hold_off_req    = 1'b0;

  function automatic int unsigned eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > ROWS_MAX) return ROWS_MAX;
    return rows_reg;
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
    return cols_reg;
  endfunction

  function automatic logic [ST_W-1:0] fire_rule(input logic [ST_W-1:0] centre, input bit hot);
    case (centre)
      ST_BURN: return ST_EMPTY;
      ST_TREE: return hot ? ST_BURN : ST_TREE;
      default: return centre;
    endcase
  endfunction

  // One input cell: result for the cell a row above, plus the last row on frame end.
  task automatic burn_generation(input logic [ST_W-1:0] raw);
    int unsigned rows, cols, r, c, x;
    logic [ST_W-1:0] cur, ns;
    bit hot, last;
    rows = eff_rows();
    cols = eff_cols();
    r = row_pos;
    c = col_pos;
    cur = (raw > ST_BURN) ? ST_EMPTY : raw;
    last = (r + 1 >= rows) && (c + 1 >= cols);
    if (c >= MAX_COLS_DEF) c = MAX_COLS_DEF - 1;
    if (r > 0) begin
      hot = (cur == ST_BURN);
      if (r >= 2 && row_above2[c] == ST_BURN) hot = 1'b1;
      if (c > 0 && row_above2[c-1] == ST_BURN) hot = 1'b1;
      if (c + 1 < cols && row_above[c+1] == ST_BURN) hot = 1'b1;
      ns = fire_rule(row_above[c], hot);
      if (ns == ST_BURN) any_burning = 1'b1;
      step_out.push_back('{ns, ROW_W'(r - 1), COL_W'(c), 1'b0, 1'b0});
    end
    row_above2[c] = row_above[c];
    row_above[c] = cur;
    if (last) begin
      for (x = 0; x < cols; x++) begin
        hot = 1'b0;
        if (r > 0 && row_above2[x] == ST_BURN) hot = 1'b1;
        if (x > 0 && row_above[x-1] == ST_BURN) hot = 1'b1;
        if (x + 1 < cols && row_above[x+1] == ST_BURN) hot = 1'b1;
        ns = fire_rule(row_above[x], hot);
        if (ns == ST_BURN) any_burning = 1'b1;
        step_out.push_back('{ns, ROW_W'(r), COL_W'(x), x + 1 == cols,
                             (x + 1 == cols) ? any_burning : 1'b0});
      end
      row_pos = 0;
      col_pos = 0;
      any_burning = 1'b0;
    end else if (c + 1 >= cols) begin
      col_pos = 0;
      row_pos = (r + 1) & 32'h3FF;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // Offer one cell and hold it until accepted; valid stays high for the caller.
  task automatic feed_cell(input logic [ST_W-1:0] raw, input bit typed, input fire_cell_t want);
    in_valid <= 1'b1;
    cell_state <= raw;
    do @(posedge clk); while (in_stall);
    step_out.delete();
    burn_generation(raw);
    if (typed) next_gen_q.push_back(want);
    else foreach (step_out[i]) next_gen_q.push_back(step_out[i]);
  endtask

  task automatic maybe_gap();
    if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drop valid, drain all results, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_ROWS, CFG_COLS: begin
        if (idx == CFG_ROWS) rows_reg = val;
        else cols_reg = val[COL_W-1:0];
        row_pos = 0;
        col_pos = 0;
        any_burning = 1'b0;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val,
                           input int frames, input bit cut_short, input bit left_ignition);
    int cells, pick;
    logic [ST_W-1:0] pick_state;
    settle();
    write_reg(CFG_ROWS, rows_val);
    write_reg(CFG_COLS, cols_val);
    cells = frames * eff_rows() * eff_cols();
    // stop part-way so the next write restarts a frame in flight
    if (cut_short && cells > 1) cells = $urandom_range(1, cells - 1);
    repeat (cells) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) pick_state = ST_EMPTY;
      else if (pick < 16) pick_state = ST_TREE;
      else if (pick < 19) pick_state = ST_BURN;
      else pick_state = ST_UNUSED;
      if (left_ignition && col_pos == 0) pick_state = ST_BURN;
      feed_cell(pick_state, 1'b0, NO_RESULT);
      maybe_gap();
      cells_fed++;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    fire_cell_t want;
    if (!rst && out_valid && !out_stall) begin
      if (next_gen_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual row %0d col %0d state %0d",
                 $time, out_row, out_col, next_state);
      end else begin
        want = next_gen_q.pop_front();
        check_field("next_state", want.state, next_state);
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("frame_end", want.fend, frame_end);
        check_field("still_burning", want.still, still_burning);
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (burst == 0 && stall_bursts_on && $urandom_range(0, 6) == 0)
          burst = $urandom_range(1, 6);
        if (burst > 0) begin
          out_stall <= 1'b1;
          burst--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] rows_val, cols_val;
    bit wide;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == WRITE_REG) begin
        settle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].value);
      end else begin
        feed_cell(DIRECTED[i].value[ST_W-1:0], DIRECTED[i].typed, DIRECTED[i].want);
        maybe_gap();
        cells_fed++;
      end
    end

    // widest rows, column count clamps to the buffer depth
    run_phase(11'd2, 11'h7FF, 1, 1'b0, 1'b1);
    // long output hold while cells keep coming
    settle();
    sender_gaps_on = 1'b0;
    hold_off_req = 1'b1;
    run_phase(11'd6, 11'd12, 1, 1'b0, 1'b0);

    while (cells_fed < ITEM_TARGET) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      stall_bursts_on = ($urandom_range(0, 3) != 0);
      wide = 1'b0;
      case ($urandom_range(0, 9))
        0: cols_val = 11'd0;
        1: cols_val = 11'd1;
        2: begin
          cols_val = 11'd48;
          wide = 1'b1;
        end
        3: begin
          cols_val = 11'($urandom_range(49, 63));
          wide = 1'b1;
        end
        default: cols_val = 11'($urandom_range(2, 12));
      endcase
      cols_val[CFG_W-1:COL_W] = 5'($urandom);
      case ($urandom_range(0, 9))
        0: rows_val = 11'd0;
        1: rows_val = 11'd1;
        default: rows_val = 11'($urandom_range(2, 8));
      endcase
      if (wide) rows_val = 11'($urandom_range(1, 2));
      run_phase(rows_val, cols_val, wide ? 1 : $urandom_range(1, 2),
                $urandom_range(0, 5) == 0, $urandom_range(0, 2) == 0);
    end

    // closing stretch at full rate on both sides
    sender_gaps_on = 1'b0;
    stall_bursts_on = 1'b0;
    run_phase(11'd4, 11'd5, 1, 1'b0, 1'b1);
    settle();
    repeat (20) @(posedge clk);

    if (errors == 0 && next_gen_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ffg_pkg.sv
hw/rtl/ffg_cell.sv
hw/rtl/ffg_chain.sv
hw/rtl/forest_fire_grid_step_top.sv
dv/forest_fire_grid_step_top_test.sv
